[rtl/vvrm_pkg.sv]
// Package: shared types and constants for the volume ramp mixer.
`timescale 1ns / 1ps
`default_nettype none
package vvrm_pkg;
  localparam int unsigned LevelW = 7;
  localparam int unsigned OutW   = 14;
  localparam int unsigned RecipW = 29;
  localparam int unsigned RecipShift = 42;
  localparam logic [13:0] FullScale = 14'h3FFF;
  localparam logic [6:0]  VolMax    = 7'h7F;
  localparam logic [6:0]  PanHalf   = 7'h40;
  // ceil(2^42 / (127 * 127)): divide by 127 twice as one multiply and shift
  localparam logic [28:0] LevelRecip = 29'd272679430;
  localparam logic        CmdStart  = 1'b0;
  localparam logic        CmdTick   = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [4:0] voice;
    logic [6:0] start_level;
    logic [6:0] target_level;
    logic [14:0] duration;
    logic [6:0] bank_volume;
    logic [6:0] prog_volume;
    logic [6:0] timbre_volume;
    logic [6:0] timbre_pan;
    logic [6:0] prog_pan;
    logic [6:0] note_pan;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  out_voice;
    logic [13:0] left_level;
    logic [13:0] right_level;
    logic [6:0]  current_level;
    logic        ramp_active;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/vvrm_in_if.sv]
// Interface: input item channel.
`timescale 1ns / 1ps
`default_nettype none
interface vvrm_in_if import vvrm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/vvrm_out_if.sv]
// Interface: result item channel.
`timescale 1ns / 1ps
`default_nettype none
interface vvrm_out_if import vvrm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/voice_volume_ramp_mixer.sv]
// Top level: per-voice volume ramp with gain and pan mixing.
`timescale 1ns / 1ps
`default_nettype none
// Each item runs through one shared multiplier under a small sequencer, with a
// restoring divider (one quotient bit per cycle) for the start plan. A start
// item holds the input through load, a 15-bit divide, plan and idle. A tick
// that falls due holds it through load, six multiply steps for the gains and
// the two divides by 127*127, three pan scalings, result and idle. A tick that
// only counts down and a start with equal levels go back to idle from load; an
// item for a voice at or above VOICE_COUNT is dropped at once. A result waits
// in the output register while the next item is taken; a due tick stalls only
// while that register is full and not being read.
module voice_volume_ramp_mixer import vvrm_pkg::*; #(
  parameter int unsigned VOICE_COUNT = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  vvrm_in_if.sink   in_if,
  vvrm_out_if.source out_if
);
  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned AccW = 28;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_DIV, S_PLAN, S_MUL, S_PAN, S_DONE
  } state_e;

  state_e state_q;
  in_item_t it_q;
  logic [VW-1:0] v_q;
  logic mono_q;

  logic [VOICE_COUNT-1:0] act_q;
  logic [7:0]  step_q [VOICE_COUNT];
  logic [14:0] intv_q [VOICE_COUNT];
  logic [15:0] cnt_q  [VOICE_COUNT];
  logic [6:0]  cur_q  [VOICE_COUNT];
  logic [6:0]  end_q  [VOICE_COUNT];

  logic [14:0]   num_q, quo_q;
  logic [14:0]   rem_q;
  logic [14:0]   den_q;
  logic [3:0]    bit_q;
  logic [2:0]    phase_q;
  logic [1:0]    pan_q;
  logic [AccW-1:0] acc_q;
  logic [OutW-1:0] left_q, right_q;
  logic [6:0]    newcur_q;
  logic          newact_q;
  out_item_t     res_q;
  logic          ovalid_q;

  logic [15:0] rem_sh;
  logic        rem_ge;
  logic [AccW-1:0] mul_a;
  logic [RecipW-1:0] mul_b;
  logic [AccW+RecipW-1:0] mul_p;
  logic [7:0]  diff, mag;
  logic [14:0] dnz;
  logic [6:0]  pan_v;
  logic        pan_r;
  logic        out_load;

  assign rem_sh = {rem_q, num_q[bit_q]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign mul_p  = {{RecipW{1'b0}}, mul_a} * {{AccW{1'b0}}, mul_b};
  assign diff   = {1'b0, it_q.target_level} - {1'b0, it_q.start_level};
  assign mag    = diff[7] ? 8'(-diff) : diff;
  assign dnz    = (it_q.duration == 15'd0) ? 15'd1 : it_q.duration;
  always_comb begin
    unique case (pan_q)
      2'd0:    pan_v = it_q.timbre_pan;
      2'd1:    pan_v = it_q.prog_pan;
      default: pan_v = it_q.note_pan;
    endcase
    pan_r = pan_v < PanHalf;
    mul_a = acc_q;
    unique case (phase_q)
      3'd0:    mul_b = {22'd0, it_q.bank_volume};
      3'd1:    mul_b = {15'd0, FullScale};
      3'd3:    mul_b = {22'd0, it_q.prog_volume};
      3'd4:    mul_b = {22'd0, it_q.timbre_volume};
      default: mul_b = LevelRecip;
    endcase
    if (phase_q == 3'd0) mul_a = {21'd0, newcur_q};
    if (state_q == S_PAN) begin
      mul_a = {14'd0, pan_r ? right_q : left_q};
      mul_b = {22'd0, pan_r ? pan_v : 7'(VolMax - pan_v)};
    end
  end

  assign out_load = (state_q == S_DONE) && (!ovalid_q || out_if.ready);
  assign in_if.ready = (state_q == S_IDLE);
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mono_q <= 1'b0;
      ovalid_q <= 1'b0;
      phase_q <= 3'd0;
      pan_q <= 2'd0;
      act_q <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        step_q[i] <= '0; intv_q[i] <= '0; cnt_q[i] <= '0;
        cur_q[i] <= '0; end_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) mono_q <= cfg_wdata_i;
      if (out_load) ovalid_q <= 1'b1;
      else if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          it_q <= in_if.data;
          v_q <= VW'(in_if.data.voice);
          if ({27'd0, in_if.data.voice} < 32'(VOICE_COUNT)) state_q <= S_LOAD;
        end
        S_LOAD: begin
          phase_q <= 3'd0;
          if (it_q.cmd == CmdStart) begin
            if (diff == 8'd0) state_q <= S_IDLE;
            else begin
              if ({7'd0, mag} < dnz) begin
                num_q <= dnz; den_q <= {7'd0, mag};
              end else begin
                num_q <= {7'd0, mag}; den_q <= dnz;
              end
              rem_q <= '0; bit_q <= 4'd14; state_q <= S_DIV;
            end
          end else if (intv_q[v_q] != 15'd0 && cnt_q[v_q] != 16'd0 && !cnt_q[v_q][15]) begin
            cnt_q[v_q] <= cnt_q[v_q] - 16'd1;
            state_q <= S_IDLE;
          end else begin
            logic [8:0] s;
            logic [8:0] e;
            logic pos, neg, hit;
            if (intv_q[v_q] != 15'd0) cnt_q[v_q] <= {1'b0, intv_q[v_q]};
            s = {1'b0, cur_q[v_q]} + {step_q[v_q][7], step_q[v_q]};
            e = {2'd0, end_q[v_q]};
            pos = !step_q[v_q][7] && step_q[v_q] != 8'd0;
            neg = step_q[v_q][7];
            hit = (pos && $signed(s) >= $signed(e)) || (neg && $signed(s) <= $signed(e));
            newact_q <= hit ? 1'b0 : act_q[v_q];
            if (hit) begin
              newcur_q <= end_q[v_q]; act_q[v_q] <= 1'b0; cur_q[v_q] <= end_q[v_q];
            end else if (s[8]) begin
              newcur_q <= 7'd0; cur_q[v_q] <= 7'd0;
            end else if (s[7]) begin
              newcur_q <= VolMax; cur_q[v_q] <= VolMax;
            end else begin
              newcur_q <= s[6:0]; cur_q[v_q] <= s[6:0];
            end
            state_q <= S_MUL;
          end
        end
        S_DIV: begin
          rem_q <= rem_ge ? 15'(rem_sh - {1'b0, den_q}) : rem_sh[14:0];
          quo_q <= {quo_q[13:0], rem_ge};
          if (bit_q == 4'd0) state_q <= S_PLAN;
          else bit_q <= bit_q - 4'd1;
        end
        S_PLAN: begin
          act_q[v_q] <= 1'b1;
          cur_q[v_q] <= it_q.start_level;
          end_q[v_q] <= it_q.target_level;
          if ({7'd0, mag} < dnz) begin
            step_q[v_q] <= diff[7] ? 8'hFF : 8'h01;
            intv_q[v_q] <= quo_q;
            cnt_q[v_q] <= {1'b0, quo_q};
          end else begin
            step_q[v_q] <= diff[7] ? 8'(-quo_q[7:0]) : quo_q[7:0];
            intv_q[v_q] <= '0;
          end
          state_q <= S_IDLE;
        end
        S_MUL: begin
          if (phase_q == 3'd5) begin
            left_q <= mul_p[RecipShift +: OutW];
            right_q <= mul_p[RecipShift +: OutW];
            pan_q <= 2'd0;
            state_q <= S_PAN;
          end else if (phase_q == 3'd2) begin
            acc_q <= {14'd0, mul_p[RecipShift +: OutW]};
          end else begin
            acc_q <= mul_p[AccW-1:0];
          end
          phase_q <= phase_q + 3'd1;
        end
        S_PAN: begin
          if (pan_r) right_q <= mul_p[6 +: OutW];
          else left_q <= mul_p[6 +: OutW];
          if (pan_q == 2'd2) state_q <= S_DONE;
          pan_q <= pan_q + 2'd1;
        end
        S_DONE: if (out_load) begin
          res_q.out_voice <= it_q.voice;
          res_q.current_level <= newcur_q;
          res_q.ramp_active <= newact_q;
          if (mono_q) begin
            res_q.left_level <= (right_q > left_q) ? right_q : left_q;
            res_q.right_level <= (right_q > left_q) ? right_q : left_q;
          end else begin
            res_q.left_level <= left_q; res_q.right_level <= right_q;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_if.ready) else $error("ready while busy");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_if.valid) else $error("result lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed while waiting");
endmodule
`default_nettype wire

[sim/voice_volume_ramp_mixer_tb.sv]
// Testbench for voice_volume_ramp_mixer: ramp starts and ticks checked against a predictor.
`timescale 1ns / 1ps
module voice_volume_ramp_mixer_tb;
  import vvrm_pkg::*;

  localparam int unsigned Voices = 24;
  localparam int unsigned DrainCycles = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  vvrm_in_if in_ch ();
  vvrm_out_if out_ch ();

  voice_volume_ramp_mixer #(.VOICE_COUNT(Voices)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  always #4 clk_i = ~clk_i;

  logic            ramp_on [Voices];
  logic [7:0]      ramp_step [Voices];
  logic [14:0]     ramp_interval [Voices];
  logic [15:0]     ramp_countdown [Voices];
  logic [6:0]      ramp_level [Voices];
  logic [6:0]      ramp_target [Voices];
  logic            mono_sel = 1'b0;

  out_item_t level_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < Voices; i++) begin
      ramp_on[i] = 0; ramp_step[i] = 0; ramp_interval[i] = 0;
      ramp_countdown[i] = 0; ramp_level[i] = 0; ramp_target[i] = 0;
    end
  end

  function automatic int unsigned pan_split(int unsigned v, int unsigned mul);
    return (v * mul) / 64;
  endfunction

  function automatic bit predict_mix(input in_item_t it, output out_item_t r);
    int v, diff, mag, d, stepv, cur;
    int unsigned lvl, left, right;
    v = it.voice;
    r = '0;
    if (v >= Voices) return 0;
    if (it.cmd == CmdStart) begin
      diff = int'(it.target_level) - int'(it.start_level);
      mag = diff < 0 ? -diff : diff;
      d = it.duration == 0 ? 1 : int'(it.duration);
      if (diff == 0) return 0;
      ramp_on[v] = 1;
      ramp_level[v] = it.start_level;
      ramp_target[v] = it.target_level;
      if (mag < d) begin
        ramp_step[v] = diff > 0 ? 8'h01 : 8'hFF;
        ramp_interval[v] = 15'(d / mag);
        ramp_countdown[v] = 16'(d / mag);
      end else begin
        ramp_step[v] = 8'(diff / d);
        ramp_interval[v] = 0;
      end
      return 0;
    end
    if (ramp_interval[v] != 0) begin
      if (ramp_countdown[v] != 0 && !ramp_countdown[v][15]) begin
        ramp_countdown[v] = ramp_countdown[v] - 16'd1;
        return 0;
      end
      ramp_countdown[v] = 16'(ramp_interval[v]);
    end
    stepv = int'($signed(ramp_step[v]));
    cur = int'(ramp_level[v]) + stepv;
    if ((stepv > 0 && cur >= int'(ramp_target[v])) ||
        (stepv < 0 && cur <= int'(ramp_target[v]))) begin
      cur = ramp_target[v];
      ramp_on[v] = 0;
    end
    if (cur < 0) cur = 0;
    if (cur > 127) cur = 127;
    ramp_level[v] = 7'(cur);
    lvl = (cur * (it.bank_volume * 32'h3FFF)) / 127 / 127;
    lvl = (lvl * it.prog_volume * it.timbre_volume) / 127 / 127;
    left = lvl;
    right = lvl;
    if (it.timbre_pan < PanHalf) right = pan_split(right, it.timbre_pan);
    else left = pan_split(left, 127 - it.timbre_pan);
    if (it.prog_pan < PanHalf) right = pan_split(right, it.prog_pan);
    else left = pan_split(left, 127 - it.prog_pan);
    if (it.note_pan < PanHalf) right = pan_split(right, it.note_pan);
    else left = pan_split(left, 127 - it.note_pan);
    if (mono_sel) begin
      if (right > left) left = right; else right = left;
    end
    r.out_voice = 5'(v);
    r.left_level = 14'(left);
    r.right_level = 14'(right);
    r.current_level = 7'(cur);
    r.ramp_active = ramp_on[v];
    return 1;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t exp_r;
    if (level_q.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    exp_r = level_q.pop_front();
    results_seen++;
    if (got.out_voice !== exp_r.out_voice) begin
      $display("%0t: out_voice exp %0d got %0d", $time, exp_r.out_voice, got.out_voice);
      errors++;
    end
    if (got.left_level !== exp_r.left_level) begin
      $display("%0t: left_level exp %0d got %0d", $time, exp_r.left_level, got.left_level);
      errors++;
    end
    if (got.right_level !== exp_r.right_level) begin
      $display("%0t: right_level exp %0d got %0d", $time, exp_r.right_level,
               got.right_level);
      errors++;
    end
    if (got.current_level !== exp_r.current_level) begin
      $display("%0t: current_level exp %0d got %0d", $time, exp_r.current_level,
               got.current_level);
      errors++;
    end
    if (got.ramp_active !== exp_r.ramp_active) begin
      $display("%0t: ramp_active exp %0d got %0d", $time, exp_r.ramp_active,
               got.ramp_active);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    out_item_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    if (predict_mix(it, r)) level_q.push_back(r);
    if (it.voice < Voices) items_sent++;
  endtask

  task automatic drain_and_set_mono(input logic mono);
    in_ch.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mono;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mono_sel = mono;
  endtask

  function automatic in_item_t rand_item(input logic cmd, input int voice);
    in_item_t it;
    it.cmd = cmd;
    it.voice = 5'(voice);
    it.start_level = 7'($urandom);
    it.target_level = 7'($urandom);
    it.duration = 15'($urandom);
    it.bank_volume = 7'($urandom);
    it.prog_volume = 7'($urandom);
    it.timbre_volume = 7'($urandom);
    it.timbre_pan = 7'($urandom);
    it.prog_pan = 7'($urandom);
    it.note_pan = 7'($urandom);
    return it;
  endfunction

  task automatic send_start(input int voice, input int s, input int t, input int dur);
    in_item_t it;
    it = rand_item(CmdStart, voice);
    it.start_level = 7'(s);
    it.target_level = 7'(t);
    it.duration = 15'(dur);
    send_item(it);
  endtask

  task automatic send_tick(input int voice, input int vol, input int pan);
    in_item_t it;
    it = rand_item(CmdTick, voice);
    if (vol >= 0) begin
      it.bank_volume = 7'(vol); it.prog_volume = 7'(vol); it.timbre_volume = 7'(vol);
    end
    if (pan >= 0) begin
      it.timbre_pan = 7'(pan); it.prog_pan = 7'(pan); it.note_pan = 7'(pan);
    end
    send_item(it);
  endtask

  task automatic test_directed();
    send_start(0, 0, 127, 0);
    send_tick(0, 127, 0);
    send_tick(0, 127, 127);
    send_start(1, 127, 0, 1);
    send_tick(1, 127, 63);
    send_start(2, 10, 12, 7);
    repeat (4) send_tick(2, 127, 64);
    send_start(3, 100, 40, 20);
    send_tick(3, 0, -1);
    send_tick(3, 127, -1);
    send_start(4, 50, 50, 9);
    send_tick(4, 127, 64);
    send_tick(23, 127, 64);
    send_start(31, 0, 127, 3);
    send_tick(31, 127, 0);
    send_start(5, 0, 1, 32767);
    repeat (2) send_tick(5, -1, -1);
    send_start(6, 127, 0, 127);
    send_tick(6, 127, 0);
  endtask

  task automatic run_random(input int n);
    int goal, voice, kind, dur, ticks;
    goal = items_sent + n;
    while (items_sent < goal) begin
      voice = ($urandom_range(0, 29) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        case ($urandom_range(0, 19))
          0, 1, 2: dur = $urandom_range(0, 32767);
          3, 4, 5, 6, 7, 8: dur = $urandom_range(9, 200);
          default: dur = $urandom_range(0, 8);
        endcase
        send_start(voice, $urandom_range(0, 127), $urandom_range(0, 127), dur);
        ticks = $urandom_range(1, 14);
        repeat (ticks) begin
          if ($urandom_range(0, 3) == 0) send_tick($urandom_range(0, 23), -1, -1);
          else send_tick(voice, -1, -1);
        end
      end else begin
        send_item(rand_item(1'($urandom), voice));
      end
    end
  endtask

  task automatic test_no_idle();
    sender_idle_pct = 0; recv_stall_pct = 0;
    run_random(300);
  endtask

  task automatic test_sender_idle();
    sender_idle_pct = 86; recv_stall_pct = 0;
    run_random(200);
  endtask

  task automatic test_receiver_stall();
    sender_idle_pct = 0; recv_stall_pct = 86;
    run_random(200);
  endtask

  task automatic test_both_idle();
    sender_idle_pct = 31; recv_stall_pct = 31;
    run_random(250);
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0; recv_stall_pct = 0;
    hold_request = 600;
    run_random(150);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain_and_set_mono(1'b1);
    test_no_idle();
    drain_and_set_mono(1'b0);
    test_sender_idle();
    test_receiver_stall();
    drain_and_set_mono(1'b1);
    test_both_idle();
    drain_and_set_mono(1'b0);
    test_backpressure();
    in_ch.valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d ramp start/tick items over both mono settings and five idle mixes,",
             items_sent);
    $display("with %0d mixed level results checked and %0d mismatches.", results_seen, errors);
    if (errors == 0) $display("voice_volume_ramp_mixer_tb passed");
    else $display("voice_volume_ramp_mixer_tb failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("voice_volume_ramp_mixer_tb failed");
    $finish;
  end
endmodule

[sim.f]
rtl/vvrm_pkg.sv
rtl/vvrm_in_if.sv
rtl/vvrm_out_if.sv
rtl/voice_volume_ramp_mixer.sv
sim/voice_volume_ramp_mixer_tb.sv
